/* design/orq_pkg.sv */
package orq_pkg;

  localparam int unsigned RecMaxW     = 64;
  localparam int unsigned CfgIdxW     = 1;
  localparam int unsigned CfgDataW    = 7;
  localparam logic [6:0]  MaxPopWords = 7'd64;

  localparam logic [1:0] OpPush  = 2'd0;
  localparam logic [1:0] OpPop   = 2'd1;
  localparam logic [1:0] OpClose = 2'd2;

  localparam logic [CfgIdxW-1:0] RegCapacity = 1'b0;
  localparam logic [CfgIdxW-1:0] RegWake     = 1'b1;

  typedef enum logic [1:0] {
    KindPush,
    KindPop,
    KindClose,
    KindNop
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [RecMaxW-1:0] rec;
    logic [6:0]         pop_max;
  } cmd_t;

  typedef struct packed {
    logic                valid;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic               accepted;
    logic               wake;
    logic               rec_valid;
    logic [RecMaxW-1:0] rec;
    logic               last;
    logic [31:0]        dsp;
    logic [6:0]         queued;
    logic [63:0]        total;
  } res_t;

endpackage

/* design/orq_fifo.sv */
module orq_fifo #(
  parameter int unsigned WIDTH   = 8,
  parameter int unsigned ENTRIES = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             valid_o
);

  localparam int unsigned PW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);

  logic [WIDTH-1:0] mem_q [ENTRIES];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(ENTRIES));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(ENTRIES - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(ENTRIES - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* design/orq_front.sv */
module orq_front #(
  parameter int unsigned RECORD_WIDTH = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push,
  output logic                    full,
  input  logic [1:0]              opcode_i,
  input  logic [RECORD_WIDTH-1:0] record_i,
  input  logic [6:0]              pop_max_i,
  output logic                    cmd_valid_o,
  output orq_pkg::cmd_t           cmd_o,
  input  logic                    cmd_pop_i
);

  orq_pkg::cmd_t                 cmd_in;
  logic [$bits(orq_pkg::cmd_t)-1:0] cmd_raw;

  always_comb begin
    cmd_in.rec     = orq_pkg::RecMaxW'(record_i);
    cmd_in.pop_max = pop_max_i;
    unique case (opcode_i)
      orq_pkg::OpPush:  cmd_in.kind = orq_pkg::KindPush;
      orq_pkg::OpPop:   cmd_in.kind = orq_pkg::KindPop;
      orq_pkg::OpClose: cmd_in.kind = orq_pkg::KindClose;
      default:          cmd_in.kind = orq_pkg::KindNop;
    endcase
  end

  orq_fifo #(
    .WIDTH  ($bits(orq_pkg::cmd_t)),
    .ENTRIES(2)
  ) u_cmd_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (cmd_in),
    .full_o (full),
    .pop_i  (cmd_pop_i),
    .data_o (cmd_raw),
    .valid_o(cmd_valid_o)
  );

  assign cmd_o = orq_pkg::cmd_t'(cmd_raw);

endmodule

/* design/orq_back.sv */
module orq_back #(
  parameter int unsigned DEPTH        = 64,
  parameter int unsigned RECORD_WIDTH = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  orq_pkg::cfg_wr_t cfg_i,
  input  logic             cmd_valid_i,
  input  orq_pkg::cmd_t    cmd_i,
  output logic             cmd_pop_o,
  input  logic             res_full_i,
  output logic             res_push_o,
  output orq_pkg::res_t    res_o
);

  localparam int unsigned AW       = $clog2(DEPTH);
  localparam int unsigned SW       = ((AW > 7) ? AW : 7) + 1;
  localparam int unsigned CapLimit = (DEPTH < 127) ? DEPTH : 127;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] a, logic [6:0] b);
    logic [SW-1:0] s;
    s = SW'(a) + SW'(b);
    if (s >= SW'(DEPTH)) begin
      s = s - SW'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  logic [RECORD_WIDTH-1:0] ring_q [DEPTH];
  logic [RECORD_WIDTH-1:0] rd_data_q;

  logic [1:0]    state_q, state_d;
  logic [AW-1:0] head_q, head_d;
  logic [6:0]    count_q, count_d;
  logic [31:0]   dsp_q, dsp_d;
  logic [63:0]   total_q, total_d;
  logic          closed_q, closed_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [6:0]    remain_q, remain_d;
  logic [31:0]   dsp_hold_q, dsp_hold_d;
  logic [6:0]    capacity_q;
  logic          wake_en_q;

  logic [6:0]    cap_eff, pop_n, pop_m;
  logic [AW-1:0] wr_addr;
  logic          mem_we;

  always_comb begin
    cap_eff = (capacity_q == '0) ? 7'd1 : capacity_q;
    if (cap_eff > 7'(CapLimit)) begin
      cap_eff = 7'(CapLimit);
    end
    pop_m = (cmd_i.pop_max < count_q) ? cmd_i.pop_max : count_q;
    pop_n = (pop_m < orq_pkg::MaxPopWords) ? pop_m : orq_pkg::MaxPopWords;
  end

  assign wr_addr = wrap_add(head_q, count_q);

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    count_d    = count_q;
    dsp_d      = dsp_q;
    total_d    = total_q;
    closed_d   = closed_q;
    rd_ptr_d   = rd_ptr_q;
    remain_d   = remain_q;
    dsp_hold_d = dsp_hold_q;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    mem_we     = 1'b0;
    res_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && !res_full_i) begin
          cmd_pop_o  = 1'b1;
          res_push_o = 1'b1;
          res_o.last = 1'b1;
          case (cmd_i.kind)
            orq_pkg::KindPush: begin
              if (!closed_q) begin
                mem_we         = 1'b1;
                res_o.accepted = 1'b1;
                res_o.wake     = (count_q == '0) && wake_en_q;
                if (count_q >= cap_eff) begin
                  head_d = wrap_add(head_q, 7'd1);
                  if (dsp_q != '1) begin
                    dsp_d = dsp_q + 32'd1;
                  end
                  if (total_q != '1) begin
                    total_d = total_q + 64'd1;
                  end
                end else begin
                  count_d = count_q + 7'd1;
                end
              end
            end
            orq_pkg::KindPop: begin
              res_o.dsp = dsp_q;
              dsp_d     = '0;
              head_d    = wrap_add(head_q, pop_n);
              count_d   = count_q - pop_n;
              if (pop_n != '0) begin
                res_push_o = 1'b0;
                dsp_hold_d = dsp_q;
                rd_ptr_d   = head_q;
                remain_d   = pop_n;
                state_d    = ST_READ;
              end
            end
            orq_pkg::KindClose: begin
              closed_d = 1'b1;
              head_d   = '0;
              count_d  = '0;
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!res_full_i) begin
          res_push_o      = 1'b1;
          res_o.rec_valid = 1'b1;
          res_o.rec       = orq_pkg::RecMaxW'(rd_data_q);
          res_o.last      = (remain_q == 7'd1);
          res_o.dsp       = dsp_hold_q;
          rd_ptr_d        = wrap_add(rd_ptr_q, 7'd1);
          remain_d        = remain_q - 7'd1;
          state_d         = (remain_q == 7'd1) ? ST_IDLE : ST_READ;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    res_o.queued = count_d;
    res_o.total  = total_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      head_q     <= '0;
      count_q    <= '0;
      dsp_q      <= '0;
      total_q    <= '0;
      closed_q   <= 1'b0;
      rd_ptr_q   <= '0;
      remain_q   <= '0;
      dsp_hold_q <= '0;
      capacity_q <= 7'd64;
      wake_en_q  <= 1'b1;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      count_q    <= count_d;
      dsp_q      <= dsp_d;
      total_q    <= total_d;
      closed_q   <= closed_d;
      rd_ptr_q   <= rd_ptr_d;
      remain_q   <= remain_d;
      dsp_hold_q <= dsp_hold_d;
      if (cfg_i.valid) begin
        unique case (cfg_i.idx)
          orq_pkg::RegCapacity: capacity_q <= cfg_i.data;
          orq_pkg::RegWake:     wake_en_q  <= cfg_i.data[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_q[wr_addr] <= cmd_i.rec[RECORD_WIDTH-1:0];
    end
    if (state_q == ST_READ) begin
      rd_data_q <= ring_q[rd_ptr_q];
    end
  end

endmodule

/* design/overwriting_ring_queue_core.sv */
// Push, close and ignored codes: one item per cycle while the result queue has
// room and no pop is in progress; the word is registered in the command queue
// and its result in the result queue. Pop: each record passes ST_READ (ring
// memory's registered read port) and ST_EMIT; no command is taken meanwhile.
// Reset (async, active low) empties the queue, clears drop counters and reopens
// it; capacity returns to 64 and wake enable to 1. Ring contents are not reset.
module overwriting_ring_queue_core #(
  parameter int unsigned DEPTH        = 64,
  parameter int unsigned RECORD_WIDTH = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic [1:0]                  opcode_i,
  input  logic [RECORD_WIDTH-1:0]     record_i,
  input  logic [6:0]                  pop_max_i,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [orq_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [orq_pkg::CfgDataW-1:0] cfg_data_i,
  output logic                        empty,
  input  logic                        pop,
  output logic                        accepted_o,
  output logic                        wake_o,
  output logic                        record_valid_o,
  output logic [RECORD_WIDTH-1:0]     record_out_o,
  output logic                        last_o,
  output logic [31:0]                 dropped_since_pop_o,
  output logic [6:0]                  queued_count_o,
  output logic [63:0]                 total_dropped_o
);

  orq_pkg::cmd_t    cmd;
  orq_pkg::cfg_wr_t cfg_wr;
  orq_pkg::res_t    res_in, res_out;
  logic             cmd_valid, cmd_pop;
  logic             res_full, res_push, res_valid;
  logic [$bits(orq_pkg::res_t)-1:0] res_raw;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr.valid = cfg_valid_i;
  assign cfg_wr.idx   = cfg_index_i;
  assign cfg_wr.data  = cfg_data_i;

  orq_front #(
    .RECORD_WIDTH(RECORD_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .opcode_i   (opcode_i),
    .record_i   (record_i),
    .pop_max_i  (pop_max_i),
    .cmd_valid_o(cmd_valid),
    .cmd_o      (cmd),
    .cmd_pop_i  (cmd_pop)
  );

  orq_back #(
    .DEPTH       (DEPTH),
    .RECORD_WIDTH(RECORD_WIDTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_wr),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd),
    .cmd_pop_o  (cmd_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res_in)
  );

  orq_fifo #(
    .WIDTH  ($bits(orq_pkg::res_t)),
    .ENTRIES(2)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_in),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (res_raw),
    .valid_o(res_valid)
  );

  assign res_out             = orq_pkg::res_t'(res_raw);
  assign empty               = !res_valid;
  assign accepted_o          = res_out.accepted;
  assign wake_o              = res_out.wake;
  assign record_valid_o      = res_out.rec_valid;
  assign record_out_o        = res_out.rec[RECORD_WIDTH-1:0];
  assign last_o              = res_out.last;
  assign dropped_since_pop_o = res_out.dsp;
  assign queued_count_o      = res_out.queued;
  assign total_dropped_o     = res_out.total;

  a_res_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !res_full)
    else $error("result word pushed into a full output queue");

  a_cmd_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_valid)
    else $error("command taken from an empty command queue");

  a_rec_not_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && record_valid_o) |-> (!accepted_o && !wake_o))
    else $error("popped record word flagged as a push result");

  a_total_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push && $past(res_push)) |-> (res_in.total >= $past(res_in.total)))
    else $error("total drop count went down");

endmodule
